// ===== hw/rtl/kpc_pkg.sv =====
package kpc_pkg;

	localparam int KEY_COUNT = 8;
	localparam int KEY_AW    = $clog2(KEY_COUNT);
	localparam int KEY_W     = 3;
	localparam int TICK_W    = 32;
	localparam int LIM_W     = 16;
	localparam int KIU_W     = 4;
	localparam int CODE_W    = 3;
	localparam int PHASE_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	localparam int EVQ_DEPTH = 8;
	localparam int EVQ_AW    = $clog2(EVQ_DEPTH);
	localparam int EVQ_CW    = EVQ_AW + 1;

	localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_DEB    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_SHORTW = 3'd2;
	localparam logic [PHASE_W-1:0] PH_HELD   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_ACCEL  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_LL     = 3'd5;

	localparam logic [CODE_W-1:0] EV_SHORT         = 3'd0;
	localparam logic [CODE_W-1:0] EV_SHORT_RELEASE = 3'd1;
	localparam logic [CODE_W-1:0] EV_LONG_ONCE     = 3'd2;
	localparam logic [CODE_W-1:0] EV_LONG_HELD     = 3'd3;
	localparam logic [CODE_W-1:0] EV_LONG_LONG     = 3'd4;
	localparam logic [CODE_W-1:0] EV_LONG_RELEASE  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_KEYS_IN_USE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_AFTER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_REPEAT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG   = 3'd6;

	localparam logic [KIU_W-1:0] RST_KEYS_IN_USE = 4'd8;
	localparam logic [LIM_W-1:0] RST_DEBOUNCE    = 16'd20;
	localparam logic [LIM_W-1:0] RST_LONG        = 16'd1000;
	localparam logic [LIM_W-1:0] RST_REPEAT      = 16'd200;
	localparam logic [LIM_W-1:0] RST_ACCEL_AFTER = 16'd3000;
	localparam logic [LIM_W-1:0] RST_FAST_REPEAT = 16'd50;
	localparam logic [LIM_W-1:0] RST_VERY_LONG   = 16'd5000;

	typedef struct packed {
		logic [KEY_W-1:0]  key_index;
		logic              pressed;
		logic [TICK_W-1:0] now_tick;
	} kpc_poll_t;

	typedef struct packed {
		logic [KEY_W-1:0]  event_key;
		logic [CODE_W-1:0] event_code;
		logic              last_event;
	} kpc_evt_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [TICK_W-1:0]  event_stamp;
		logic [TICK_W-1:0]  phase_stamp;
	} kpc_ent_t;

	localparam int ENT_W = $bits(kpc_ent_t);

endpackage

// ===== hw/rtl/kpc_ram.sv =====
module kpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/multi_key_press_classifier_core.sv =====
// Multi-key press classifier.
// poll channel (poll_valid/poll_stall/poll): one poll of one key with its
//   pressed level and the current tick. A request is taken when valid is high
//   and stall is low.
// evt channel (evt_valid/evt_stall/evt): classified key events, zero to two
//   per poll, the final one of a poll flagged by last_event.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): timing registers,
//   always ready; write only while the block is idle.
// Throughput: one poll per cycle while poll_stall is low. The per-key state
//   sits in a synchronous RAM; a poll reads it in the cycle it is taken and
//   writes it back in the next cycle, with a bypass for back-to-back polls of one key.
// With the queue empty, the first event of a poll reaches evt through the s1 poll
//   registers and then the event queue; a second event of that poll follows it.
// Events wait in an 8-entry queue; when the receiver stalls the queue fills
//   and poll_stall rises once fewer than two slots are sure to be free.
// Reset: all keys idle with zero stamps (per-key valid flags, no RAM sweep),
//   registers at their default values, queue empty.
module multi_key_press_classifier_core
	import kpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 poll_valid,
	output logic                 poll_stall,
	input  kpc_poll_t            poll,
	output logic                 evt_valid,
	input  logic                 evt_stall,
	output kpc_evt_t             evt,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	logic [KIU_W-1:0] kiu_q;
	logic [LIM_W-1:0] dbn_q, long_q, rpt_q, accel_q, fast_q, vlong_q;

	logic                    poll_acc;
	logic                    v_s1, act_s1, pressed_s1;
	logic [KEY_W-1:0]        key_s1;
	logic [TICK_W-1:0]       now_s1;
	logic [KEY_COUNT-1:0]    vld_q;
	logic                    fwd_v_q;
	logic [KEY_W-1:0]        fwd_key_q;
	kpc_ent_t                fwd_ent_q;
	logic [ENT_W-1:0]        ram_rdata;
	kpc_ent_t                cur, nxt;
	logic                    ram_we;
	logic [TICK_W-1:0]       de, dp;
	logic [LIM_W-1:0]        ev_lim, ph_lim;
	logic                    ev_hit, ph_hit;
	logic                    e0v, e1v;
	logic [CODE_W-1:0]       c0, c1;
	logic [1:0]              push_n;

	kpc_evt_t                evq_q [EVQ_DEPTH];
	logic [EVQ_AW-1:0]       head_q, tail_q, tail_p1;
	logic [EVQ_CW-1:0]       cnt_q;
	logic                    evt_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kiu_q   <= RST_KEYS_IN_USE;
			dbn_q   <= RST_DEBOUNCE;
			long_q  <= RST_LONG;
			rpt_q   <= RST_REPEAT;
			accel_q <= RST_ACCEL_AFTER;
			fast_q  <= RST_FAST_REPEAT;
			vlong_q <= RST_VERY_LONG;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEYS_IN_USE: kiu_q   <= cfg_data[KIU_W-1:0];
				REG_DEBOUNCE:    dbn_q   <= cfg_data;
				REG_LONG:        long_q  <= cfg_data;
				REG_REPEAT:      rpt_q   <= cfg_data;
				REG_ACCEL_AFTER: accel_q <= cfg_data;
				REG_FAST_REPEAT: fast_q  <= cfg_data;
				REG_VERY_LONG:   vlong_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// room for the worst case: two events from the poll in flight and two from this one
	assign poll_stall = (cnt_q + (v_s1 ? EVQ_CW'(2) : EVQ_CW'(0))) > EVQ_CW'(EVQ_DEPTH - 2);
	assign poll_acc   = poll_valid && !poll_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= poll_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_acc) begin
			key_s1     <= poll.key_index;
			pressed_s1 <= poll.pressed;
			now_s1     <= poll.now_tick;
			act_s1     <= ({1'b0, poll.key_index} < kiu_q) && (32'(poll.key_index) < KEY_COUNT);
		end
	end

	kpc_ram #(
		.WIDTH(ENT_W),
		.DEPTH(KEY_COUNT)
	) u_state_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(key_s1[KEY_AW-1:0]),
		.wdata(nxt),
		.re   (poll_acc),
		.raddr(poll.key_index[KEY_AW-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (fwd_v_q && (fwd_key_q == key_s1)) begin
			cur = fwd_ent_q;
		end else if (vld_q[key_s1[KEY_AW-1:0]]) begin
			cur = kpc_ent_t'(ram_rdata);
		end else begin
			cur = '0;
		end
	end

	assign de = now_s1 - cur.event_stamp;
	assign dp = now_s1 - cur.phase_stamp;

	always_comb begin
		unique case (cur.phase)
			PH_DEB:    ev_lim = dbn_q;
			PH_SHORTW: ev_lim = long_q;
			PH_HELD:   ev_lim = rpt_q;
			default:   ev_lim = fast_q;
		endcase
		ph_lim = (cur.phase == PH_HELD) ? accel_q : vlong_q;
	end

	assign ev_hit = de >= {{(TICK_W-LIM_W){1'b0}}, ev_lim};
	assign ph_hit = dp >= {{(TICK_W-LIM_W){1'b0}}, ph_lim};

	always_comb begin
		nxt    = cur;
		ram_we = v_s1 && act_s1;
		e0v    = 1'b0;
		e1v    = 1'b0;
		c0     = EV_SHORT;
		c1     = EV_SHORT;
		if (v_s1 && act_s1) begin
			unique case (cur.phase)
				PH_IDLE: begin
					if (pressed_s1) begin
						nxt.event_stamp = now_s1;
						nxt.phase       = PH_DEB;
					end
				end
				PH_DEB: begin
					if (ev_hit) begin
						if (pressed_s1) begin
							e0v       = 1'b1;
							c0        = EV_SHORT;
							nxt.phase = PH_SHORTW;
						end else begin
							nxt.phase = PH_IDLE;
						end
					end
				end
				PH_SHORTW: begin
					if (pressed_s1) begin
						if (ev_hit) begin
							e0v             = 1'b1;
							c0              = EV_LONG_ONCE;
							nxt.event_stamp = now_s1;
							nxt.phase_stamp = now_s1;
							nxt.phase       = PH_HELD;
						end
					end else begin
						e0v       = 1'b1;
						c0        = EV_SHORT_RELEASE;
						nxt.phase = PH_IDLE;
					end
				end
				PH_HELD: begin
					if (pressed_s1) begin
						if (ev_hit) begin
							e0v             = 1'b1;
							c0              = EV_LONG_HELD;
							nxt.event_stamp = now_s1;
						end
						if (ph_hit) begin
							nxt.phase_stamp = now_s1;
							nxt.phase       = PH_ACCEL;
						end
					end else begin
						e0v       = 1'b1;
						c0        = EV_LONG_RELEASE;
						nxt.phase = PH_IDLE;
					end
				end
				PH_ACCEL: begin
					if (pressed_s1) begin
						if (ev_hit) begin
							e0v             = 1'b1;
							c0              = EV_LONG_HELD;
							nxt.event_stamp = now_s1;
						end
						if (ph_hit) begin
							if (ev_hit) begin
								e1v = 1'b1;
								c1  = EV_LONG_LONG;
							end else begin
								e0v = 1'b1;
								c0  = EV_LONG_LONG;
							end
							nxt.phase_stamp = now_s1;
							nxt.phase       = PH_LL;
						end
					end else begin
						e0v       = 1'b1;
						c0        = EV_LONG_RELEASE;
						nxt.phase = PH_IDLE;
					end
				end
				PH_LL: begin
					if (pressed_s1) begin
						if (ev_hit) begin
							e0v             = 1'b1;
							c0              = EV_LONG_HELD;
							nxt.event_stamp = now_s1;
						end
					end else begin
						e0v       = 1'b1;
						c0        = EV_LONG_RELEASE;
						nxt.phase = PH_IDLE;
					end
				end
				default: begin
					nxt.phase = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			fwd_v_q <= 1'b0;
		end else begin
			fwd_v_q <= ram_we;
			if (ram_we) begin
				vld_q[key_s1[KEY_AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			fwd_key_q <= key_s1;
			fwd_ent_q <= nxt;
		end
	end

	assign push_n  = {1'b0, e0v} + {1'b0, e1v};
	assign tail_p1 = tail_q + 1'b1;
	assign evt_pop = evt_valid && !evt_stall;

	always_ff @(posedge clk) begin
		if (e0v) begin
			evq_q[tail_q] <= '{event_key: key_s1, event_code: c0, last_event: !e1v};
		end
		if (e1v) begin
			evq_q[tail_p1] <= '{event_key: key_s1, event_code: c1, last_event: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			tail_q <= tail_q + EVQ_AW'(push_n);
			if (evt_pop) begin
				head_q <= head_q + 1'b1;
			end
			cnt_q <= cnt_q + EVQ_CW'(push_n) - EVQ_CW'(evt_pop);
		end
	end

	assign evt_valid = cnt_q != '0;
	assign evt       = evq_q[head_q];

	a_evq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= EVQ_CW'(EVQ_DEPTH))
		else $error("event queue over capacity");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (cnt_q + EVQ_CW'(push_n)) <= EVQ_CW'(EVQ_DEPTH))
		else $error("event push without room");

	a_we_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> v_s1 && act_s1)
		else $error("state write without an active poll");

	a_legal_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> nxt.phase <= PH_LL)
		else $error("unknown phase written back");

	a_two_from_accel: assert property (@(posedge clk) disable iff (!arst_n)
		e1v |-> e0v && (cur.phase == PH_ACCEL) && (nxt.phase == PH_LL))
		else $error("second event outside accelerated phase");

endmodule

// ===== dv/multi_key_press_classifier_core_tb.sv =====
module multi_key_press_classifier_core_tb;
	import kpc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int unsigned CYCLE_LIMIT = 200000;

	class key_event_board;
		logic [KIU_W-1:0]   key_limit;
		logic [LIM_W-1:0]   lim_debounce;
		logic [LIM_W-1:0]   lim_long;
		logic [LIM_W-1:0]   lim_repeat;
		logic [LIM_W-1:0]   lim_accel;
		logic [LIM_W-1:0]   lim_fast;
		logic [LIM_W-1:0]   lim_very_long;
		logic [PHASE_W-1:0] phase[KEY_COUNT];
		logic [TICK_W-1:0]  ev_stamp[KEY_COUNT];
		logic [TICK_W-1:0]  ph_stamp[KEY_COUNT];
		kpc_evt_t           due[$];
		int                 errors;
		int                 polls_seen;
		int                 polls_used;
		int                 events_seen;

		function new();
			key_limit     = RST_KEYS_IN_USE;
			lim_debounce  = RST_DEBOUNCE;
			lim_long      = RST_LONG;
			lim_repeat    = RST_REPEAT;
			lim_accel     = RST_ACCEL_AFTER;
			lim_fast      = RST_FAST_REPEAT;
			lim_very_long = RST_VERY_LONG;
			for (int i = 0; i < KEY_COUNT; i++) begin
				phase[i]    = PH_IDLE;
				ev_stamp[i] = '0;
				ph_stamp[i] = '0;
			end
			errors      = 0;
			polls_seen  = 0;
			polls_used  = 0;
			events_seen = 0;
		endfunction

		function int live_keys();
			return (int'(key_limit) > KEY_COUNT) ? KEY_COUNT : int'(key_limit);
		endfunction

		function int outstanding();
			return due.size();
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) $display("%s", msg);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
			REG_KEYS_IN_USE: key_limit = data[KIU_W-1:0];
			REG_DEBOUNCE:    lim_debounce = data;
			REG_LONG:        lim_long = data;
			REG_REPEAT:      lim_repeat = data;
			REG_ACCEL_AFTER: lim_accel = data;
			REG_FAST_REPEAT: lim_fast = data;
			REG_VERY_LONG:   lim_very_long = data;
			default: ;
			endcase
		endfunction

		// wrapping tick difference against a 16-bit limit
		function bit timed_out(logic [TICK_W-1:0] stamp, logic [TICK_W-1:0] now,
				logic [LIM_W-1:0] lim);
			logic [TICK_W-1:0] diff;
			diff = now - stamp;
			return diff >= {{(TICK_W - LIM_W){1'b0}}, lim};
		endfunction

		function void take_poll(kpc_poll_t p);
			logic [KEY_W-1:0]  k;
			logic [TICK_W-1:0] now;
			logic [CODE_W-1:0] codes[$];
			kpc_evt_t          e;
			polls_seen++;
			k = p.key_index;
			now = p.now_tick;
			if (int'(k) >= live_keys()) return;
			polls_used++;
			case (phase[k])
			PH_IDLE: begin
				if (p.pressed) begin
					ev_stamp[k] = now;
					phase[k] = PH_DEB;
				end
			end
			PH_DEB: begin
				if (timed_out(ev_stamp[k], now, lim_debounce)) begin
					if (p.pressed) begin
						codes.push_back(EV_SHORT);
						phase[k] = PH_SHORTW;
					end else begin
						phase[k] = PH_IDLE;
					end
				end
			end
			PH_SHORTW: begin
				if (!p.pressed) begin
					codes.push_back(EV_SHORT_RELEASE);
					phase[k] = PH_IDLE;
				end else if (timed_out(ev_stamp[k], now, lim_long)) begin
					codes.push_back(EV_LONG_ONCE);
					ev_stamp[k] = now;
					ph_stamp[k] = now;
					phase[k] = PH_HELD;
				end
			end
			PH_HELD: begin
				if (!p.pressed) begin
					codes.push_back(EV_LONG_RELEASE);
					phase[k] = PH_IDLE;
				end else begin
					if (timed_out(ev_stamp[k], now, lim_repeat)) begin
						codes.push_back(EV_LONG_HELD);
						ev_stamp[k] = now;
					end
					if (timed_out(ph_stamp[k], now, lim_accel)) begin
						ph_stamp[k] = now;
						phase[k] = PH_ACCEL;
					end
				end
			end
			PH_ACCEL: begin
				if (!p.pressed) begin
					codes.push_back(EV_LONG_RELEASE);
					phase[k] = PH_IDLE;
				end else begin
					if (timed_out(ev_stamp[k], now, lim_fast)) begin
						codes.push_back(EV_LONG_HELD);
						ev_stamp[k] = now;
					end
					if (timed_out(ph_stamp[k], now, lim_very_long)) begin
						codes.push_back(EV_LONG_LONG);
						ph_stamp[k] = now;
						phase[k] = PH_LL;
					end
				end
			end
			PH_LL: begin
				if (!p.pressed) begin
					codes.push_back(EV_LONG_RELEASE);
					phase[k] = PH_IDLE;
				end else if (timed_out(ev_stamp[k], now, lim_fast)) begin
					codes.push_back(EV_LONG_HELD);
					ev_stamp[k] = now;
				end
			end
			default: phase[k] = PH_IDLE;
			endcase
			foreach (codes[i]) begin
				e.event_key  = k;
				e.event_code = codes[i];
				e.last_event = (i == codes.size() - 1);
				due.push_back(e);
			end
		endfunction

		function void match_event(kpc_evt_t got);
			kpc_evt_t want;
			events_seen++;
			if (due.size() == 0) begin
				flag($sformatf("unexpected event: key %0d code %0d last %0d",
					got.event_key, got.event_code, got.last_event));
				return;
			end
			want = due.pop_front();
			if (got.event_key !== want.event_key || got.event_code !== want.event_code ||
					got.last_event !== want.last_event)
				flag($sformatf({"event mismatch: expected key %0d code %0d last %0d, ",
					"got key %0d code %0d last %0d"},
					want.event_key, want.event_code, want.last_event,
					got.event_key, got.event_code, got.last_event));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 poll_valid = 1'b0;
	logic                 poll_stall;
	kpc_poll_t            poll = '0;
	logic                 evt_valid;
	logic                 evt_stall = 1'b0;
	kpc_evt_t             evt;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	key_event_board    sb = new();
	int                idle_max = 5;
	int                settings_run = 1;
	int unsigned       cycle_count = 0;
	logic [TICK_W-1:0] tick_now = '0;
	bit                held_level[KEY_COUNT];

	multi_key_press_classifier_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.poll_valid (poll_valid),
		.poll_stall (poll_stall),
		.poll       (poll),
		.evt_valid  (evt_valid),
		.evt_stall  (evt_stall),
		.evt        (evt),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events still due", cycle_count,
				sb.outstanding());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// event receiver: random stall before each event
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
			if (gap != 0) begin
				evt_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				evt_stall <= 1'b0;
			end
			do @(posedge clk); while (!evt_valid);
			sb.match_event(evt);
		end
	end

	task automatic send_poll(kpc_poll_t p);
		int gap;
		gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
		if (gap != 0) begin
			poll_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		poll_valid <= 1'b1;
		poll <= p;
		do @(posedge clk); while (poll_stall);
		sb.take_poll(p);
	endtask

	task automatic poll_at(int k, bit pr, logic [TICK_W-1:0] t);
		kpc_poll_t p;
		p.key_index = KEY_W'(k);
		p.pressed   = pr;
		p.now_tick  = t;
		send_poll(p);
	endtask

	task automatic settle();
		poll_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_burst(logic [CFG_DAT_W-1:0] kiu, logic [CFG_DAT_W-1:0] deb,
			logic [CFG_DAT_W-1:0] lng, logic [CFG_DAT_W-1:0] rpt,
			logic [CFG_DAT_W-1:0] acc, logic [CFG_DAT_W-1:0] fst,
			logic [CFG_DAT_W-1:0] vl, bit spare);
		logic [CFG_IDX_W-1:0] idx[8];
		logic [CFG_DAT_W-1:0] val[8];
		int n;
		idx[0] = REG_KEYS_IN_USE; val[0] = kiu;
		idx[1] = REG_DEBOUNCE;    val[1] = deb;
		idx[2] = REG_LONG;        val[2] = lng;
		idx[3] = REG_REPEAT;      val[3] = rpt;
		idx[4] = REG_ACCEL_AFTER; val[4] = acc;
		idx[5] = REG_FAST_REPEAT; val[5] = fst;
		idx[6] = REG_VERY_LONG;   val[6] = vl;
		idx[7] = REG_UNUSED;      val[7] = CFG_DAT_W'($urandom);
		n = spare ? 8 : 7;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	// held keys with random tick steps, plus stray levels, foreign keys and tick jumps
	task automatic run_random(int want_polls, int max_step);
		int done;
		int k;
		int live;
		kpc_poll_t p;
		done = 0;
		live = sb.live_keys();
		tick_now = $urandom;
		while (done < want_polls) begin
			if (live == 0 || $urandom_range(0, 9) == 0) k = $urandom_range(0, KEY_COUNT - 1);
			else k = $urandom_range(0, live - 1);
			if ($urandom_range(0, 9) == 0) held_level[k] = !held_level[k];
			tick_now = tick_now + TICK_W'($urandom_range(0, max_step));
			if ($urandom_range(0, 49) == 0) tick_now = $urandom;
			p.key_index = KEY_W'(k);
			p.pressed   = ($urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1)) : held_level[k];
			p.now_tick  = tick_now;
			send_poll(p);
			if (live == 0 || k < live) done++;
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default timing: debounce, short release across the tick wrap, full long chain
		idle_max = 5;
		poll_at(7, 1'b1, 32'hFFFF_FFF0);
		poll_at(7, 1'b1, 32'h0000_0004);
		poll_at(7, 1'b0, 32'h0000_000E);
		poll_at(0, 1'b1, 32'd0);
		poll_at(0, 1'b1, 32'd20);
		poll_at(0, 1'b1, 32'd1000);
		poll_at(0, 1'b1, 32'd1200);
		poll_at(0, 1'b1, 32'd4000);
		poll_at(0, 1'b1, 32'd4050);
		poll_at(0, 1'b1, 32'd9000);
		poll_at(0, 1'b1, 32'd9050);
		poll_at(0, 1'b0, 32'd9060);
		poll_at(7, 1'b1, 32'hFFFF_FFFF);
		poll_at(7, 1'b0, 32'h0000_0013);
		settle();

		// zero limits fire on every poll; key count above the key range
		cfg_burst(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
		poll_at(3, 1'b1, 32'd0);
		poll_at(3, 1'b1, 32'd0);
		poll_at(3, 1'b1, 32'd0);
		poll_at(3, 1'b1, 32'd0);
		poll_at(3, 1'b0, 32'd0);
		poll_at(6, 1'b1, 32'hFFFF_FFFF);
		poll_at(6, 1'b1, 32'hFFFF_FFFF);
		poll_at(6, 1'b1, 32'hFFFF_FFFF);
		poll_at(6, 1'b1, 32'hFFFF_FFFF);
		poll_at(6, 1'b1, 32'hFFFF_FFFF);
		poll_at(6, 1'b1, 32'hFFFF_FFFF);
		poll_at(6, 1'b0, 32'hFFFF_FFFF);
		run_random(50, 2);
		settle();

		cfg_burst(16'd5, 16'd2, 16'd12, 16'd3, 16'd16, 16'd1, 16'd10, 1'b0);
		run_random(60, 3);
		settle();

		// no active keys, plus a write to an unmapped index
		cfg_burst(16'd0, 16'd4, 16'd9, 16'd2, 16'd7, 16'd1, 16'd5, 1'b1);
		run_random(12, 5);
		settle();

		idle_max = 0;
		cfg_burst(16'd8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		run_random(60, 30000);
		settle();

		idle_max = 5;
		cfg_burst(16'd3, 16'd5, 16'd30, 16'd7, 16'd40, 16'd2, 16'd25, 1'b0);
		run_random(60, 6);
		settle();

		idle_max = 0;
		cfg_burst(16'd1, 16'd1, 16'd4, 16'd2, 16'd6, 16'd1, 16'd5, 1'b0);
		run_random(60, 2);
		settle();

		idle_max = 5;
		cfg_burst(16'd7, 16'd20, 16'd1000, 16'd200, 16'd3000, 16'd50, 16'd5000, 1'b0);
		run_random(60, 400);

		poll_valid <= 1'b0;
		for (int n = 0; n < 5000 && sb.outstanding() != 0; n++) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.outstanding() != 0)
			sb.flag($sformatf("%0d expected events never arrived", sb.outstanding()));

		$display("Covered %0d key polls (%0d on active keys) over %0d timing setups",
			sb.polls_seen, sb.polls_used, settings_run);
		$display("Checked %0d key events, %0d mismatches", sb.events_seen, sb.errors);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/kpc_pkg.sv
hw/rtl/kpc_ram.sv
hw/rtl/multi_key_press_classifier_core.sv
dv/multi_key_press_classifier_core_tb.sv
